[rtl/core/edge_persistence_foreground_top_macros.svh]
// Assertion macros for the edge persistence foreground block.
// Used by edge_persistence_foreground_top; depends on nothing else.
`ifndef EDGE_PERSISTENCE_FOREGROUND_TOP_MACROS_SVH
`define EDGE_PERSISTENCE_FOREGROUND_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/epf_pkg.sv]
// Shared constants for the edge persistence foreground block.
// Used by edge_persistence_foreground_top and its testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package epf_pkg;

    localparam int MAX_PIXELS  = 524288;
    localparam int COUNT_BITS  = 16;
    localparam int INDEX_W     = 19;
    localparam int ADDR_W      = $clog2(MAX_PIXELS);
    localparam int PIX_W       = 8;
    localparam int FRAME_W     = 16;
    localparam int RATIO_W     = 17;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = RATIO_W + FRAME_W;
    localparam int SHIFT_W     = COUNT_BITS + FRAC_BITS;
    localparam int CMP_W       = (SHIFT_W > PROD_W) ? SHIFT_W : PROD_W;

    localparam logic [PIX_W-1:0]      EDGE_VALUE  = 8'd255;
    localparam logic [RATIO_W-1:0]    RATIO_RESET = 17'd32768;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [INDEX_W:0]      INDEX_LIMIT = (INDEX_W+1)'(MAX_PIXELS);

endpackage

`default_nettype wire

[rtl/core/edge_persistence_foreground_top.sv]
// Edge persistence foreground detector: per-pixel edge counts in one RAM.
// An accepted input beat passes through stage registers 1 to 4 to o_valid; one beat per cycle while o_stall is low.
// The rate is set by the count RAM's one read and one write port per cycle; the
// read-modify-write loop is closed by forwarding from the two younger stages.
// After reset the count RAM is cleared one entry a cycle, with o_stall high;
// configuration writes are accepted throughout.
// Depends on epf_pkg, epf_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "edge_persistence_foreground_top_macros.svh"

module edge_persistence_foreground_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [epf_pkg::RATIO_W-1:0]    i_cfg_wr_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [epf_pkg::INDEX_W-1:0]    i_pixel_index,
    input  wire logic [epf_pkg::PIX_W-1:0]      i_pixel_value,
    input  wire logic [epf_pkg::FRAME_W-1:0]    i_frame_number,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic      [epf_pkg::INDEX_W-1:0]    o_out_index,
    output logic                                o_is_foreground,
    output logic      [epf_pkg::COUNT_BITS-1:0] o_edge_count
);

    import epf_pkg::*;

    // Configuration and clearing pass.
    logic [RATIO_W-1:0] r_ratio;
    logic               r_clearing;
    logic [ADDR_W-1:0]  r_clr_addr;

    // Pipeline stage registers.
    logic                  r_v1, r_v2, r_v3, r_v4;
    logic [INDEX_W-1:0]    r_idx1, r_idx2, r_idx3, r_idx4;
    logic                  r_inr1, r_inr2, r_inr3;
    logic                  r_edge1, r_edge2;
    logic [FRAME_W-1:0]    r_frame1, r_frame2;
    logic [COUNT_BITS-1:0] r_cnt2, r_cnt3, r_cnt4;
    logic                  r_fg_ok3;
    logic [PROD_W-1:0]     r_prod3;
    logic                  r_fg4;

    logic                  adv;
    logic                  accept;
    logic                  in_range;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] base_cnt;
    logic [COUNT_BITS-1:0] n_cnt2;
    logic [PROD_W-1:0]     n_prod3;
    logic                  n_fg4;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;

    assign adv      = !r_v4 || !i_stall;
    assign o_stall  = r_clearing || !adv;
    assign accept   = i_valid && !o_stall;
    assign in_range = ({1'b0, i_pixel_index} < INDEX_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio    <= RATIO_RESET;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ratio <= i_cfg_wr_data;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(MAX_PIXELS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    // The oldest pending writer sits in stage 2 and writes as it moves on.
    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = r_v2 && r_inr2 && adv;
            ram_waddr = r_idx2[ADDR_W-1:0];
            ram_wdata = r_cnt2;
        end
    end

    epf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_PIXELS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (i_pixel_index[ADDR_W-1:0]),
        .o_rdata (rd_cnt)
    );

    // Stage 1: the RAM word can be stale by up to two younger updates to the
    // same pixel; the nearer one wins.
    always_comb begin
        if (r_v2 && r_inr2 && (r_idx2 == r_idx1)) begin
            base_cnt = r_cnt2;
        end else if (r_v3 && r_inr3 && (r_idx3 == r_idx1)) begin
            base_cnt = r_cnt3;
        end else begin
            base_cnt = rd_cnt;
        end
        if (!r_inr1) begin
            n_cnt2 = '0;
        end else if (r_edge1 && (base_cnt != COUNT_MAX)) begin
            n_cnt2 = base_cnt + 1'b1;
        end else begin
            n_cnt2 = base_cnt;
        end
    end

    // Stage 2: ratio times frame number. Stage 3: compare against count << 16.
    assign n_prod3 = PROD_W'(r_ratio) * PROD_W'(r_frame2);
    assign n_fg4   = r_fg_ok3 &&
                     (CMP_W'({r_cnt3, {FRAC_BITS{1'b0}}}) <= CMP_W'(r_prod3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_idx1   <= i_pixel_index;
            r_inr1   <= in_range;
            r_edge1  <= (i_pixel_value == EDGE_VALUE);
            r_frame1 <= i_frame_number;

            r_idx2   <= r_idx1;
            r_inr2   <= r_inr1;
            r_edge2  <= r_edge1;
            r_frame2 <= r_frame1;
            r_cnt2   <= n_cnt2;

            r_idx3   <= r_idx2;
            r_inr3   <= r_inr2;
            r_cnt3   <= r_cnt2;
            r_prod3  <= n_prod3;
            r_fg_ok3 <= r_inr2 && r_edge2 && (r_frame2 != '0);

            r_idx4   <= r_idx3;
            r_cnt4   <= r_cnt3;
            r_fg4    <= n_fg4;
        end
    end

    assign o_valid         = r_v4;
    assign o_out_index     = r_idx4;
    assign o_is_foreground = r_fg4;
    assign o_edge_count    = r_cnt4;

    `EPF_ASSERT_IMP(a_no_accept_while_clearing, r_clearing, o_stall, "beat accepted during clear")
    `EPF_ASSERT_IMP(a_pipe_empty_while_clearing, r_clearing, !(r_v1 || r_v2 || r_v3 || r_v4), "pipeline busy during clear")
    `EPF_ASSERT_IMP(a_fg_needs_count, r_v4 && r_fg4, r_cnt4 != '0, "foreground with zero count")
    `EPF_ASSERT_NXT(a_hold_stage1, r_v1 && !adv, r_v1 && $stable(r_idx1) && $stable(rd_cnt), "stage 1 moved while held")

endmodule

`default_nettype wire

[rtl/core/epf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Read returns the old contents when read and write hit the same address.
`timescale 1ns / 1ps
`default_nettype none

module epf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[tb/edge_persistence_foreground_top_tb.sv]
// Self-checking testbench for edge_persistence_foreground_top.
// Runs directed rows and random phases against a behavioral predictor.
// Depends on epf_pkg and the RTL of the block.
`timescale 1ns / 1ps

module edge_persistence_foreground_top_tb;

    import epf_pkg::*;

    localparam int  TIMEOUT_CYCLES = 2000000;
    localparam int  DRAIN_CYCLES   = 8;
    localparam int  PHASE_ITEMS    = 210;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  HOT_COUNT      = 8;

    typedef struct {
        logic [INDEX_W-1:0]    index;
        logic                  fg;
        logic [COUNT_BITS-1:0] count;
    } t_pixel_result;

    typedef struct {
        logic [INDEX_W-1:0]    index;
        logic [PIX_W-1:0]      value;
        logic [FRAME_W-1:0]    frame;
        bit                    typed;
        logic                  fg;
        logic [COUNT_BITS-1:0] count;
    } t_directed_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [RATIO_W-1:0]    i_cfg_wr_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [INDEX_W-1:0]    i_pixel_index;
    logic [PIX_W-1:0]      i_pixel_value;
    logic [FRAME_W-1:0]    i_frame_number;
    logic                  o_valid;
    logic                  i_stall;
    logic [INDEX_W-1:0]    o_out_index;
    logic                  o_is_foreground;
    logic [COUNT_BITS-1:0] o_edge_count;

    edge_persistence_foreground_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel_index   (i_pixel_index),
        .i_pixel_value   (i_pixel_value),
        .i_frame_number  (i_frame_number),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_index     (o_out_index),
        .o_is_foreground (o_is_foreground),
        .o_edge_count    (o_edge_count)
    );

    // Predictor state: per-pixel edge counts (absent means zero) and the ratio.
    logic [COUNT_BITS-1:0] edge_count_store [logic [INDEX_W-1:0]];
    logic [RATIO_W-1:0]    ratio_setting;
    t_pixel_result         pending_results [$];

    int  fail_count;
    int  cycle_count;
    bit  sender_quiet;
    bit  sink_quiet;
    int  hold_requests;
    int  hold_served;
    int  hold_left;
    logic [INDEX_W-1:0] hot_pixels [HOT_COUNT];

    // Expected row values follow from the reset ratio of one half.
    t_directed_row directed_rows [17] = '{
        '{19'd0,      8'd255, 16'd0,      1'b1, 1'b0, 16'd1},  // frame zero is never foreground
        '{19'd0,      8'd255, 16'd4,      1'b1, 1'b1, 16'd2},  // same pixel back to back
        '{19'd0,      8'd255, 16'd1,      1'b1, 1'b0, 16'd3},
        '{19'd524287, 8'd254, 16'd65535,  1'b1, 1'b0, 16'd0},  // one below the edge value
        '{19'd524287, 8'd255, 16'd65535,  1'b1, 1'b1, 16'd1},
        '{19'd524287, 8'd0,   16'd0,      1'b1, 1'b0, 16'd1},  // non-edge keeps the count
        '{19'd1,      8'd255, 16'd65535,  1'b1, 1'b1, 16'd1},
        '{19'h55555,  8'hAA,  16'hAAAA,   1'b1, 1'b0, 16'd0},
        '{19'h2AAAA,  8'h55,  16'h5555,   1'b1, 1'b0, 16'd0},
        '{19'h2AAAA,  8'd255, 16'd2,      1'b1, 1'b1, 16'd1},  // ratio exactly met
        '{19'h2AAAA,  8'd255, 16'd2,      1'b1, 1'b0, 16'd2},
        '{19'h2AAAA,  8'd255, 16'd4,      1'b0, 1'b0, 16'd0},
        '{19'd1,      8'd128, 16'd1,      1'b0, 1'b0, 16'd0},
        '{19'd0,      8'd255, 16'd6,      1'b0, 1'b0, 16'd0},
        '{19'd0,      8'd255, 16'd10,     1'b0, 1'b0, 16'd0},
        '{19'd2,      8'd255, 16'd65535,  1'b0, 1'b0, 16'd0},
        '{19'd2,      8'd255, 16'd1,      1'b0, 1'b0, 16'd0}
    };

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    function automatic logic [COUNT_BITS-1:0] stored_count(input logic [INDEX_W-1:0] idx);
        return edge_count_store.exists(idx) ? edge_count_store[idx] : '0;
    endfunction

    function automatic t_pixel_result predict_pixel(input logic [INDEX_W-1:0] idx,
                                                    input logic [PIX_W-1:0] val,
                                                    input logic [FRAME_W-1:0] frame);
        t_pixel_result         res;
        logic [COUNT_BITS-1:0] cnt;
        logic [CMP_W:0]        scaled_count;
        logic [CMP_W:0]        allowed;
        bit                    is_edge;
        res.index = idx;
        res.fg    = 1'b0;
        res.count = '0;
        if (int'(idx) < MAX_PIXELS) begin
            is_edge = (val == EDGE_VALUE);
            cnt = stored_count(idx);
            if (is_edge && cnt != COUNT_MAX)
                cnt = cnt + 1'b1;
            edge_count_store[idx] = cnt;
            scaled_count = (CMP_W+1)'(cnt) << FRAC_BITS;
            allowed = (CMP_W+1)'(ratio_setting) * (CMP_W+1)'(frame);
            res.fg = is_edge && frame != '0 && scaled_count <= allowed;
            res.count = cnt;
        end
        return res;
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_quiet || r < 75)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Offers one beat and holds it until the block takes it. Called on a rising edge.
    task automatic send_pixel(input logic [INDEX_W-1:0] idx, input logic [PIX_W-1:0] val,
                              input logic [FRAME_W-1:0] frame, input int gap,
                              input bit use_typed, input t_pixel_result typed_res);
        t_pixel_result predicted;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_pixel_index  <= idx;
        i_pixel_value  <= val;
        i_frame_number <= frame;
        do @(posedge i_clk); while (o_stall);
        predicted = predict_pixel(idx, val, frame);
        pending_results.push_back(use_typed ? typed_res : predicted);
    endtask

    task automatic write_ratio(input logic [RATIO_W-1:0] value);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ratio_setting = value;
    endtask

    // Most beats hit a few hot pixels with frame numbers near their counts, so the
    // foreground decision lands close to its boundary; the rest is broad noise.
    task automatic run_random_phase(input int items);
        t_pixel_result         unused;
        logic [INDEX_W-1:0]    idx;
        logic [PIX_W-1:0]      val;
        logic [FRAME_W-1:0]    frame;
        int                    cnt;
        int                    hi;
        int                    r;
        unused = '{default: '0};
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            idx = (r < 70) ? hot_pixels[$urandom_range(0, HOT_COUNT-1)]
                           : INDEX_W'($urandom_range(0, MAX_PIXELS-1));
            val = ($urandom_range(0, 99) < 60) ? EDGE_VALUE : PIX_W'($urandom_range(0, 255));
            cnt = int'(stored_count(idx));
            hi = (2 * cnt + 2 > 65535) ? 65535 : 2 * cnt + 2;
            r = $urandom_range(0, 99);
            if (r < 5)
                frame = '0;
            else if (r < 65)
                frame = FRAME_W'($urandom_range(cnt, hi));
            else
                frame = FRAME_W'($urandom_range(0, 65535));
            send_pixel(idx, val, frame, sender_gap(), 1'b0, unused);
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        t_pixel_result typed_res;
        fail_count     = 0;
        sender_quiet   = 1'b0;
        sink_quiet     = 1'b0;
        hold_requests  = 0;
        ratio_setting  = RATIO_RESET;
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        i_valid        <= 1'b0;
        i_pixel_index  <= '0;
        i_pixel_value  <= '0;
        i_frame_number <= '0;
        hot_pixels[0] = 19'd0;
        hot_pixels[1] = 19'd1;
        hot_pixels[2] = 19'd2;
        hot_pixels[3] = 19'd524287;
        hot_pixels[4] = 19'h2AAAA;
        for (int i = 5; i < HOT_COUNT; i++)
            hot_pixels[i] = INDEX_W'($urandom_range(0, MAX_PIXELS-1));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block clears its count store first; the first beat simply waits.
        foreach (directed_rows[i]) begin
            typed_res = '{directed_rows[i].index, directed_rows[i].fg, directed_rows[i].count};
            send_pixel(directed_rows[i].index, directed_rows[i].value, directed_rows[i].frame,
                       sender_gap(), directed_rows[i].typed, typed_res);
        end
        i_valid <= 1'b0;

        // A ratio of zero never admits an edge pixel as foreground.
        write_ratio('0);
        run_random_phase(PHASE_ITEMS);

        // Full ratio, with neither side idling.
        write_ratio(RATIO_W'(65536));
        sender_quiet = 1'b1;
        sink_quiet   = 1'b1;
        run_random_phase(PHASE_ITEMS);
        sink_quiet = 1'b0;

        // The receiver holds off for a long stretch while beats keep coming.
        write_ratio(RATIO_W'($urandom_range(16384, 49152)));
        hold_requests++;
        run_random_phase(PHASE_ITEMS);
        sender_quiet = 1'b0;

        write_ratio(RATIO_W'($urandom_range(0, 65536)));
        run_random_phase(PHASE_ITEMS);

        write_ratio(RATIO_W'($urandom_range(1, 65535)));
        run_random_phase(PHASE_ITEMS);

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: short and occasional long stalls, quiet stretches, and one long hold-off.
    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            hold_left   = 0;
            hold_served = 0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            i_stall   <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
        end else if (sink_quiet) begin
            i_stall <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_stall <= 1'b0;
            end else if (r < 97) begin
                i_stall   <= 1'b1;
                hold_left = $urandom_range(0, 2);
            end else begin
                i_stall   <= 1'b1;
                hold_left = $urandom_range(9, 39);
            end
        end
    end

    initial begin
        i_stall = 1'b0;
    end

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat for pixel %0d with no expectation waiting", o_out_index);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_index !== want.index) begin
                    $error("out_index: expected %0d, actual %0d", want.index, o_out_index);
                    fail_count++;
                end
                if (o_is_foreground !== want.fg) begin
                    $error("is_foreground: expected %0d, actual %0d", want.fg, o_is_foreground);
                    fail_count++;
                end
                if (o_edge_count !== want.count) begin
                    $error("edge_count: expected %0d, actual %0d", want.count, o_edge_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
    end

endmodule
